// ===== rtl/bitmap_best_fit_block_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define BBFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== rtl/bbfa_pkg.sv =====
package bbfa_pkg;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int BS_W           = 17;
  localparam int BIU_W          = 11;
  localparam int DVD_W          = 33;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

  localparam logic [BS_W-1:0]  BS_RESET  = 17'd4096;
  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADARG  = 2'd2,
    ST_NOTHING = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_SCAN_END,
    S_MUL,
    S_MARK,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        action;
    logic [31:0] request_size;
    logic [31:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_offset;
    logic [10:0] block_total;
    status_t     status;
  } rsp_t;

endpackage

// ===== rtl/bbfa_div.sv =====
module bbfa_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bbfa_pkg::DVD_W-1:0] dividend,
  input  logic [bbfa_pkg::BS_W-1:0]  divisor,
  output logic                      done,
  output logic [bbfa_pkg::DVD_W-1:0] quotient,
  output logic [bbfa_pkg::BS_W-1:0]  remainder
);
  import bbfa_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVD_W-1:0] quo;
  logic [BS_W-1:0]  rem;
  logic [BS_W-1:0]  dvs;
  logic [BS_W:0]    rem_sh;
  logic [BS_W:0]    rem_sub;

  assign rem_sh  = {rem, quo[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sub[BS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[BS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/bbfa_map.sv =====
module bbfa_map #(
  parameter int MAX_BLOCKS = bbfa_pkg::DEF_MAX_BLOCKS,
  parameter int AW         = $clog2(MAX_BLOCKS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  output logic          ready
);
  logic          mem [MAX_BLOCKS];
  logic          clearing;
  logic [AW-1:0] clr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
      if (clr_ptr == AW'(MAX_BLOCKS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_ptr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule

// ===== rtl/bitmap_best_fit_block_allocator.sv =====
// Best-fit block allocator over a one-bit-per-block used map held in a
// synchronous RAM. One request is in flight at a time. After reset the RAM is
// swept clear before the first request is taken. An allocate runs a serial
// division, streams the map once, forms the offset in S_SCAN_END and S_MUL,
// then marks each granted block. A free runs the division, then reads and
// clears each used block in turn (read, then write back).
`include "bitmap_best_fit_block_allocator_defines.svh"
module bitmap_best_fit_block_allocator #(
  parameter int MAX_BLOCKS = bbfa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  bbfa_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output bbfa_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bbfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbfa_pkg::BS_W-1:0]      cfg_data
);
  import bbfa_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);

  state_t           state, state_next;
  logic [BS_W-1:0]  bs;
  logic [BIU_W-1:0] biu;
  logic [LW-1:0]    lim;

  logic             act, act_next;
  logic [DVD_W-1:0] need, need_next;
  logic [DVD_W:0]   want, want_next;
  logic             cur_val, cur_val_next;
  logic [LW-1:0]    run_len, run_len_next;
  logic [LW-1:0]    run_start, run_start_next;
  logic [LW-1:0]    best_len, best_len_next;
  logic [LW-1:0]    best_start, best_start_next;
  logic [LW-1:0]    p, p_next;
  logic             rv, rv_next;
  logic [LW-1:0]    raddr_d, raddr_d_next;
  logic [LW-1:0]    ptr, ptr_next;
  logic [LW-1:0]    cnt, cnt_next;
  logic [31:0]      prod, prod_next;
  rsp_t             res, res_next;
  rsp_t             rsp_next;
  logic             rsp_valid_next;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic [BS_W-1:0]  div_r;

  logic             rd_en, rd_data, wr_en, wr_data, map_ready;
  logic [AW-1:0]    rd_addr, wr_addr;

  logic             cand;
  logic             issue;
  logic [LW-1:0]    first;
  logic [LW+BS_W-1:0] mul_prod;

  always_comb begin
    if (32'(biu) > 32'(MAX_BLOCKS)) begin
      lim = LW'(MAX_BLOCKS);
    end else begin
      lim = LW'(biu);
    end
  end

  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      bs  <= BS_RESET;
      biu <= BIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_SIZE:    bs  <= cfg_data;
        REG_BLOCKS_IN_USE: biu <= cfg_data[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  bbfa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (bs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  bbfa_map #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .AW         (AW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .ready   (map_ready)
  );

  assign req_stall = !(state == S_IDLE && map_ready);
  assign cand      = !cur_val && ({{(DVD_W + 1 - LW){1'b0}}, run_len} >= want) &&
                     (best_len == '0 || run_len < best_len);
  assign issue     = p < lim;
  assign first     = best_start + 1'b1;
  assign mul_prod  = (LW + BS_W)'(first) * (LW + BS_W)'(bs);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rv        <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      rv        <= rv_next;
    end
  end

  always_ff @(posedge clk) begin
    act        <= act_next;
    need       <= need_next;
    want       <= want_next;
    cur_val    <= cur_val_next;
    run_len    <= run_len_next;
    run_start  <= run_start_next;
    best_len   <= best_len_next;
    best_start <= best_start_next;
    p          <= p_next;
    raddr_d    <= raddr_d_next;
    ptr        <= ptr_next;
    cnt        <= cnt_next;
    prod       <= prod_next;
    res        <= res_next;
    rsp        <= rsp_next;
  end

  always_comb begin
    state_next      = state;
    act_next        = act;
    need_next       = need;
    want_next       = want;
    cur_val_next    = cur_val;
    run_len_next    = run_len;
    run_start_next  = run_start;
    best_len_next   = best_len;
    best_start_next = best_start;
    p_next          = p;
    rv_next         = 1'b0;
    raddr_d_next    = raddr_d;
    ptr_next        = ptr;
    cnt_next        = cnt;
    prod_next       = prod;
    res_next        = res;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && rsp_stall;
    div_start       = 1'b0;
    div_dvd         = {1'b0, req.free_offset};
    rd_en           = 1'b0;
    rd_addr         = p[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = ptr[AW-1:0];
    wr_data         = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_valid && !req_stall) begin
          act_next = req.action;
          res_next = '{granted_offset: '0, block_total: '0, status: ST_OK};
          if (bs == '0 || (!req.action && req.request_size == '0)) begin
            res_next.status = ST_BADARG;
            state_next      = S_DONE;
          end else begin
            div_start = 1'b1;
            if (!req.action) begin
              div_dvd = {1'b0, req.request_size} + DVD_W'(bs) - DVD_W'(1);
            end
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (!act) begin
            need_next       = div_q;
            want_next       = {1'b0, div_q} + (DVD_W + 1)'(2);
            cur_val_next    = 1'b1;
            run_len_next    = '0;
            run_start_next  = '0;
            best_len_next   = '0;
            best_start_next = '0;
            p_next          = '0;
            state_next      = S_SCAN;
          end else if (div_r != '0) begin
            res_next.status = ST_BADARG;
            state_next      = S_DONE;
          end else if (div_q >= DVD_W'(lim)) begin
            res_next.status = ST_NOTHING;
            state_next      = S_DONE;
          end else begin
            ptr_next   = div_q[LW-1:0];
            cnt_next   = '0;
            state_next = S_FREE_RD;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_en        = 1'b1;
          p_next       = p + 1'b1;
          rv_next      = 1'b1;
          raddr_d_next = p;
        end
        if (rv) begin
          if (rd_data == cur_val) begin
            run_len_next = run_len + 1'b1;
          end else begin
            if (cand) begin
              best_len_next   = run_len;
              best_start_next = run_start;
            end
            cur_val_next   = rd_data;
            run_start_next = raddr_d;
            run_len_next   = LW'(1);
          end
        end
        if (!issue && !rv) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (cand) begin
          best_len_next   = run_len;
          best_start_next = run_start;
        end
        if (cand || best_len != '0) begin
          state_next = S_MUL;
        end else begin
          res_next.status = ST_NOFIT;
          state_next      = S_DONE;
        end
      end
      S_MUL: begin
        prod_next                = mul_prod[31:0];
        cnt_next                 = '0;
        res_next.block_total     = need[10:0];
        state_next               = S_MARK;
      end
      S_MARK: begin
        wr_en   = 1'b1;
        wr_data = 1'b1;
        wr_addr = AW'(first + cnt);
        cnt_next = cnt + 1'b1;
        if (cnt == need[LW-1:0] - 1'b1) begin
          res_next.granted_offset = prod;
          state_next              = S_DONE;
        end
      end
      S_FREE_RD: begin
        if (ptr < lim) begin
          rd_en      = 1'b1;
          rd_addr    = ptr[AW-1:0];
          state_next = S_FREE_CHK;
        end else begin
          res_next.block_total = 11'(cnt);
          res_next.status      = (cnt == '0) ? ST_NOTHING : ST_OK;
          state_next           = S_DONE;
        end
      end
      S_FREE_CHK: begin
        if (rd_data) begin
          wr_en      = 1'b1;
          wr_data    = 1'b0;
          ptr_next   = ptr + 1'b1;
          cnt_next   = cnt + 1'b1;
          state_next = S_FREE_RD;
        end else begin
          res_next.block_total = 11'(cnt);
          res_next.status      = (cnt == '0) ? ST_NOTHING : ST_OK;
          state_next           = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `BBFA_ASSERT_NOW(a_err_zero, rsp_valid && rsp.status != ST_OK, rsp.granted_offset == '0 && rsp.block_total == '0)
  `BBFA_ASSERT_NOW(a_mark_sets, state == S_MARK, wr_en && wr_data)
  `BBFA_ASSERT_NEXT(a_chk_after_rd, state == S_FREE_RD && ptr < lim, state == S_FREE_CHK)
  `BBFA_ASSERT_NOW(a_no_req_busy, state != S_IDLE, req_stall)

endmodule
